[rtl/wbs_pkg.sv]
// ----------------------------------------------------------------------------
// wbs_pkg: shared types and constants of the write-back save scheduler
// Holds operation codes, status codes, item and result structures and the
// sequencer states.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int OWNER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(OWNER_SLOTS);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CNT_W       = $clog2(OWNER_SLOTS + 1);

  localparam logic [31:0] AGE_FLUSH_RST    = 32'd30000;
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd5000;
  localparam logic [15:0] CHANGE_THR_RST   = 16'd64;
  localparam logic [4:0]  IN_FLIGHT_RST    = 5'd4;
  localparam logic [4:0]  CREDIT_MAX       = 5'd16;
  localparam logic [31:0] M32              = 32'hFFFF_FFFF;

  // input kind codes
  localparam logic [2:0] KIND_OPEN     = 3'd0;
  localparam logic [2:0] KIND_DIRTY    = 3'd1;
  localparam logic [2:0] KIND_FLUSH    = 3'd2;
  localparam logic [2:0] KIND_CAPTURE  = 3'd3;
  localparam logic [2:0] KIND_SCAN     = 3'd4;
  localparam logic [2:0] KIND_COMPLETE = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSLOT  = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_STALE   = 3'd3;
  localparam logic [2:0] ST_REVEXH  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_AGE       = 2'd0;
  localparam logic [1:0] CFG_INTERVAL  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_LIMIT     = 2'd3;

  typedef enum logic [2:0] {
    OP_OPEN, OP_DIRTY, OP_FLUSH, OP_CAPTURE, OP_SCAN, OP_COMPLETE, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_EXEC, S_SCAN_CHK, S_SCAN_STEP, S_SCAN_END
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  slot;
    logic [31:0] now_ms;
    logic [7:0]  change_count;
    logic        final_save;
    logic [4:0]  scan_budget;
    logic [31:0] gen_in;
    logic [31:0] rev_in;
    logic        success;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [31:0] rev;
  } result_t;

  typedef struct packed {
    logic [31:0] age_flush_ms;
    logic [31:0] min_interval_ms;
    logic [15:0] change_threshold;
    logic [4:0]  in_flight_limit;
  } cfg_t;

  typedef struct packed {
    logic       idle;
    logic [4:0] outstanding;
  } back_stat_t;

endpackage

[rtl/write_back_save_scheduler.sv]
// ----------------------------------------------------------------------------
// write_back_save_scheduler: per-slot write-back save scheduler
// Queues commands in a front end and runs them on a slot table in a back end.
// ----------------------------------------------------------------------------
// Order: with the back end free, a single-slot item is dequeued into the
//   item register, looked up in a registered slot read, applied, and its
//   result set in the output register. The back end takes the next item
//   only after the last; scans use a one-slot-per-cycle cursor walk.
// Reset: synchronous, active low; clears slot flags, credits and queue.
// Results are a one-cycle strobe; the receiver cannot stall.
module write_back_save_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_change_count,
  input  logic        in_final_save,
  input  logic [4:0]  in_scan_budget,
  input  logic [31:0] in_gen_in,
  input  logic [31:0] in_rev_in,
  input  logic        in_success,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_gen_out,
  output logic [31:0] out_rev_out,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import wbs_pkg::*;

  cfg_t       cfg_r;
  logic       q_valid, q_pop;
  item_t      q_item;
  result_t    res;
  back_stat_t stat;

  // configuration registers: write in place, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_flush_ms     <= AGE_FLUSH_RST;
      cfg_r.min_interval_ms  <= MIN_INTERVAL_RST;
      cfg_r.change_threshold <= CHANGE_THR_RST;
      cfg_r.in_flight_limit  <= IN_FLIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AGE:       cfg_r.age_flush_ms     <= cfg_data;
        CFG_INTERVAL:  cfg_r.min_interval_ms  <= cfg_data;
        CFG_THRESHOLD: cfg_r.change_threshold <= cfg_data[15:0];
        CFG_LIMIT:     cfg_r.in_flight_limit  <= cfg_data[4:0];
        default:       ;
      endcase
    end
  end

  // front end: accept and decode each item, hold it in the queue
  wbs_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_slot, .in_now_ms, .in_change_count, .in_final_save,
    .in_scan_budget, .in_gen_in, .in_rev_in, .in_success,
    .q_valid, .q_item, .q_pop
  );

  // back end: advance through the slot table and emit results
  wbs_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_valid, .q_item, .q_pop,
    .res_valid(out_valid), .res, .res_last(out_last), .stat
  );

  assign out_status   = res.status;
  assign out_slot_out = res.slot;
  assign out_gen_out  = res.gen;
  assign out_rev_out  = res.rev;

`ifndef SYNTHESIS
  // credits never exceed the hard cap
  a_credit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.outstanding <= CREDIT_MAX) else $error("credit count above cap");
  // the closing result of an item is never followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result right after last");
  // a missing slot reports no generation
  a_noslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOSLOT) |-> (out_gen_out == '0))
    else $error("missing slot with generation");
  // results only come from a working back end
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.idle && $past(stat.idle) && $past(stat.idle, 2) |-> !out_valid)
    else $error("result while idle");
`endif

endmodule

[rtl/wbs_front.sv]
// ----------------------------------------------------------------------------
// wbs_front: command intake
// Accepts items, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
module wbs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     in_kind,
  input  logic [3:0]     in_slot,
  input  logic [31:0]    in_now_ms,
  input  logic [7:0]     in_change_count,
  input  logic           in_final_save,
  input  logic [4:0]     in_scan_budget,
  input  logic [31:0]    in_gen_in,
  input  logic [31:0]    in_rev_in,
  input  logic           in_success,
  output logic           q_valid,
  output wbs_pkg::item_t q_item,
  input  logic           q_pop
);
  import wbs_pkg::*;

  item_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                push;
  item_t               dec;

  always_comb begin
    dec = '0;
    case (in_kind)
      KIND_OPEN:     dec.op = OP_OPEN;
      KIND_DIRTY:    dec.op = OP_DIRTY;
      KIND_FLUSH:    dec.op = OP_FLUSH;
      KIND_CAPTURE:  dec.op = OP_CAPTURE;
      KIND_SCAN:     dec.op = OP_SCAN;
      KIND_COMPLETE: dec.op = OP_COMPLETE;
      default:       dec.op = OP_BAD;
    endcase
    dec.slot         = in_slot;
    dec.now_ms       = in_now_ms;
    dec.change_count = in_change_count;
    dec.final_save   = in_final_save;
    dec.scan_budget  = in_scan_budget;
    dec.gen_in       = in_gen_in;
    dec.rev_in       = in_rev_in;
    dec.success      = in_success;
  end

  assign busy    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end

endmodule

[rtl/wbs_back.sv]
// ----------------------------------------------------------------------------
// wbs_back: slot table and operation sequencer
// Reads one slot per single-slot item, evaluates the due tests, applies
// the update and emits results; scans step one slot per cycle to valid slots.
// ----------------------------------------------------------------------------
module wbs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wbs_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  wbs_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                res_valid,
  output wbs_pkg::result_t    res,
  output logic                res_last,
  output wbs_pkg::back_stat_t stat
);
  import wbs_pkg::*;

  // slot table (payload, written before read)
  logic [31:0] gen_r  [OWNER_SLOTS];
  logic [31:0] cur_r  [OWNER_SLOTS];
  logic [31:0] com_r  [OWNER_SLOTS];
  logic [31:0] prev_r [OWNER_SLOTS];
  logic [31:0] ds_r   [OWNER_SLOTS];
  logic [15:0] ct_r   [OWNER_SLOTS];
  logic [31:0] lst_r  [OWNER_SLOTS];
  logic [31:0] ret_r  [OWNER_SLOTS];
  logic [OWNER_SLOTS-1:0] valid_r, pend_r, flush_r;

  state_t state_r, state_nxt;
  item_t  it_r;
  logic [SLOT_W-1:0] a_r, pos_r, cursor_r, p1;
  logic [4:0]  outst_r, lim;
  logic [31:0] next_gen_r;
  logic [4:0]  ex_r, cand_r, cnt_vld;
  logic        held_v_r;
  result_t     held_r;

  // registered look-up of slot a_r
  logic        f_eq_cc_r, f_pend_eq_r, f_early_r, f_age_r, f_chg_r, f_cmpl_r, f_max_r;
  logic [31:0] rd_gen_r, rd_cur_r, rd_retry_r;
  logic [15:0] rd_sum_r;

  // sequencer strobes
  logic do_pop, do_eval, do_exec, do_step, do_end;

  // exec datapath
  logic    grant, cap_req, credit_ok, scan_go;
  result_t ex_res;
  logic    ex_emit;

  assign lim       = (cfg.in_flight_limit > CREDIT_MAX) ? CREDIT_MAX : cfg.in_flight_limit;
  assign credit_ok = (outst_r < lim);
  assign p1        = pos_r + 1'b1;
  assign cnt_vld   = 5'($countones(valid_r));
  assign scan_go   = (cnt_vld != '0) && credit_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.op == OP_SCAN) ? S_SCAN_CHK : S_EVAL;
        end
      end
      S_EVAL:      state_nxt = S_EXEC;
      S_EXEC:      state_nxt = (it_r.op == OP_SCAN) ? S_SCAN_CHK : S_IDLE;
      S_SCAN_CHK:  state_nxt = ((ex_r < cand_r) && credit_ok) ? S_SCAN_STEP : S_SCAN_END;
      S_SCAN_STEP: state_nxt = valid_r[p1] ? S_EVAL : S_SCAN_STEP;
      S_SCAN_END:  state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    do_pop  = 1'b0;
    do_eval = 1'b0;
    do_exec = 1'b0;
    do_step = 1'b0;
    do_end  = 1'b0;
    case (state_r)
      S_IDLE:      do_pop  = q_valid;
      S_EVAL:      do_eval = 1'b1;
      S_EXEC:      do_exec = 1'b1;
      S_SCAN_CHK:  ;
      S_SCAN_STEP: do_step = 1'b1;
      S_SCAN_END:  do_end  = 1'b1;
      default:     ;
    endcase
  end

  assign q_pop = do_pop;

  // capture decision on the looked-up flags
  assign cap_req = (it_r.op == OP_CAPTURE) || (it_r.op == OP_SCAN);
  always_comb begin
    logic fin;
    fin   = (it_r.op == OP_CAPTURE) && it_r.final_save;
    grant = !pend_r[a_r] && credit_ok && !f_eq_cc_r && !(!fin && f_early_r)
            && (fin || flush_r[a_r] || f_age_r || f_chg_r);
  end

  // single-slot result
  always_comb begin
    ex_res      = '0;
    ex_res.slot = it_r.slot;
    ex_emit     = 1'b1;
    if (it_r.op == OP_BAD) begin
      ex_res.status = ST_REFUSED;
    end else if (it_r.op == OP_SCAN) begin
      ex_res.status = ST_OK;
      ex_res.slot   = 4'(a_r);
      ex_res.gen    = rd_gen_r;
      ex_res.rev    = rd_cur_r;
      ex_emit       = grant;
    end else if (it_r.op == OP_OPEN) begin
      if (valid_r[a_r]) begin
        ex_res.status = ST_OK;
        ex_res.gen    = rd_gen_r;
        ex_res.rev    = rd_cur_r;
      end else if (next_gen_r == M32) begin
        ex_res.status = ST_REFUSED;
      end else begin
        ex_res.status = ST_OK;
        ex_res.gen    = next_gen_r;
      end
    end else if (!valid_r[a_r]) begin
      ex_res.status = ST_NOSLOT;
    end else begin
      ex_res.gen = rd_gen_r;
      ex_res.rev = rd_cur_r;
      case (it_r.op)
        OP_DIRTY: begin
          if (f_max_r) begin
            ex_res.status = ST_REVEXH;
          end else begin
            ex_res.rev = rd_cur_r + 32'd1;
          end
        end
        OP_CAPTURE: ex_res.status = grant ? ST_OK : ST_REFUSED;
        OP_COMPLETE: begin
          if (f_cmpl_r) begin
            ex_res.rev = it_r.rev_in;
          end else begin
            ex_res.status = ST_STALE;
          end
        end
        default: ;
      endcase
    end
  end

  // look-up stage
  always_ff @(posedge clk) begin
    if (do_eval) begin
      logic [16:0] sum;
      logic [32:0] rt;
      sum = {1'b0, ct_r[a_r]} + 17'(it_r.change_count);
      rt  = {1'b0, it_r.now_ms} + {1'b0, cfg.min_interval_ms};
      f_eq_cc_r   <= (cur_r[a_r] == com_r[a_r]);
      f_pend_eq_r <= pend_r[a_r] && (cur_r[a_r] == prev_r[a_r]);
      f_early_r   <= (it_r.now_ms < ret_r[a_r]);
      f_age_r     <= (it_r.now_ms >= ds_r[a_r])
                     && ((it_r.now_ms - ds_r[a_r]) >= cfg.age_flush_ms);
      f_chg_r     <= (ct_r[a_r] >= cfg.change_threshold) && (it_r.now_ms >= lst_r[a_r])
                     && ((it_r.now_ms - lst_r[a_r]) >= cfg.min_interval_ms);
      f_cmpl_r    <= (gen_r[a_r] == it_r.gen_in) && pend_r[a_r]
                     && (prev_r[a_r] == it_r.rev_in);
      f_max_r     <= (cur_r[a_r] == M32);
      rd_gen_r    <= gen_r[a_r];
      rd_cur_r    <= cur_r[a_r];
      rd_sum_r    <= sum[16] ? 16'hFFFF : sum[15:0];
      rd_retry_r  <= rt[32] ? M32 : rt[31:0];
    end
  end

  // slot table payload writes
  always_ff @(posedge clk) begin
    if (do_exec && (it_r.op != OP_BAD)) begin
      if (it_r.op == OP_OPEN) begin
        if (!valid_r[a_r] && (next_gen_r != M32)) begin
          gen_r[a_r]  <= next_gen_r;
          cur_r[a_r]  <= '0;
          com_r[a_r]  <= '0;
          prev_r[a_r] <= '0;
          ds_r[a_r]   <= '0;
          ct_r[a_r]   <= '0;
          lst_r[a_r]  <= '0;
          ret_r[a_r]  <= '0;
        end
      end else if (valid_r[a_r]) begin
        if ((it_r.op == OP_DIRTY) && !f_max_r) begin
          if (f_eq_cc_r || f_pend_eq_r) begin
            ds_r[a_r] <= it_r.now_ms;
          end
          cur_r[a_r] <= rd_cur_r + 32'd1;
          ct_r[a_r]  <= rd_sum_r;
        end
        if (cap_req && grant) begin
          prev_r[a_r] <= rd_cur_r;
          ct_r[a_r]   <= '0;
          lst_r[a_r]  <= it_r.now_ms;
        end
        if ((it_r.op == OP_COMPLETE) && f_cmpl_r) begin
          if (it_r.success) begin
            com_r[a_r] <= it_r.rev_in;
            ret_r[a_r] <= '0;
          end else begin
            ret_r[a_r] <= rd_retry_r;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      pend_r     <= '0;
      flush_r    <= '0;
      outst_r    <= '0;
      next_gen_r <= 32'd1;
      cursor_r   <= SLOT_W'(OWNER_SLOTS - 1);
      held_v_r   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_valid <= (do_exec && ((it_r.op == OP_SCAN) ? (grant && held_v_r) : ex_emit))
                   || do_end;
      if (do_pop) begin
        it_r     <= q_item;
        a_r      <= q_item.slot[SLOT_W-1:0];
        pos_r    <= cursor_r;
        ex_r     <= '0;
        held_v_r <= 1'b0;
        cand_r   <= !scan_go ? 5'd0 :
                    (q_item.scan_budget < cnt_vld) ? q_item.scan_budget : cnt_vld;
      end
      if (do_step) begin
        pos_r <= p1;
        if (valid_r[p1]) begin
          cursor_r <= p1;
          a_r      <= p1;
        end
      end
      if (do_exec) begin
        if (it_r.op == OP_SCAN) begin
          ex_r <= ex_r + 5'd1;
          if (grant) begin
            // hold the newest grant; release the previous one
            held_r   <= ex_res;
            held_v_r <= 1'b1;
            if (held_v_r) begin
              res      <= held_r;
              res_last <= 1'b0;
            end
          end
        end else begin
          res      <= ex_res;
          res_last <= 1'b1;
        end
        if (it_r.op == OP_OPEN && !valid_r[a_r] && (next_gen_r != M32)) begin
          valid_r[a_r] <= 1'b1;
          pend_r[a_r]  <= 1'b0;
          flush_r[a_r] <= 1'b0;
          next_gen_r   <= next_gen_r + 32'd1;
        end
        if ((it_r.op != OP_BAD) && (it_r.op != OP_OPEN) && valid_r[a_r]) begin
          if ((it_r.op == OP_FLUSH) && !f_eq_cc_r && !f_pend_eq_r) begin
            flush_r[a_r] <= 1'b1;
          end
          if (cap_req && grant) begin
            pend_r[a_r]  <= 1'b1;
            flush_r[a_r] <= 1'b0;
            outst_r      <= outst_r + 5'd1;
          end
          if ((it_r.op == OP_COMPLETE) && f_cmpl_r) begin
            if (outst_r != '0) begin
              outst_r <= outst_r - 5'd1;
            end
            pend_r[a_r] <= 1'b0;
            if (!it_r.success) begin
              flush_r[a_r] <= 1'b1;
            end
          end
        end
      end
      if (do_end) begin
        res_last <= 1'b1;
        res      <= held_v_r ? held_r : result_t'{status: ST_REFUSED, default: '0};
      end
    end
  end

  assign stat.idle        = (state_r == S_IDLE);
  assign stat.outstanding = outst_r;

endmodule

[dv/tb_write_back_save_scheduler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_write_back_save_scheduler: self-checking bench for the save scheduler
// Drives command items with random gaps and rewrites the configuration registers
// between phases. A scoreboard class keeps its own copy of the slot table and
// predicts every result strobe, which is checked field by field in order.
// ----------------------------------------------------------------------------
import wbs_pkg::*;

class save_sched_sb;
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [31:0] rev;
    logic        last;
  } sched_result_t;

  // register copies
  logic [31:0] age_flush, min_gap;
  logic [15:0] chg_thr;
  logic [4:0]  credit_reg;

  // slot table copy
  bit          opened [16];
  logic [31:0] gen_of [16];
  logic [31:0] cur_rev [16];
  logic [31:0] done_rev [16];
  bit          in_flight [16];
  logic [31:0] flight_rev [16];
  logic [31:0] dirty_at [16];
  logic [15:0] chg_sum [16];
  logic [31:0] saved_at [16];
  logic [31:0] retry_at [16];
  bit          flush_req [16];
  bit          failed [16];
  int unsigned busy_saves;
  int unsigned cursor;
  logic [31:0] gen_next;

  sched_result_t expected_results [$];
  int errors;

  function new();
    age_flush  = AGE_FLUSH_RST;
    min_gap    = MIN_INTERVAL_RST;
    chg_thr    = CHANGE_THR_RST;
    credit_reg = IN_FLIGHT_RST;
    for (int i = 0; i < 16; i++) begin
      opened[i] = 0; gen_of[i] = 0; cur_rev[i] = 0; done_rev[i] = 0;
      in_flight[i] = 0; flight_rev[i] = 0; dirty_at[i] = 0; chg_sum[i] = 0;
      saved_at[i] = 0; retry_at[i] = 0; flush_req[i] = 0; failed[i] = 0;
    end
    busy_saves = 0;
    cursor     = 15;
    gen_next   = 1;
    errors     = 0;
  endfunction

  function void cfg_write(logic [1:0] idx, logic [31:0] d);
    case (idx)
      CFG_AGE:       age_flush  = d;
      CFG_INTERVAL:  min_gap    = d;
      CFG_THRESHOLD: chg_thr    = d[15:0];
      default:       credit_reg = d[4:0];
    endcase
  endfunction

  function int unsigned credits();
    return (credit_reg > CREDIT_MAX) ? 16 : credit_reg;
  endfunction

  function void push(logic [2:0] st, logic [3:0] sl, logic [31:0] g, logic [31:0] r,
                     logic lst);
    sched_result_t e;
    e = '{st, sl, g, r, lst};
    expected_results.insert(expected_results.size(), e);
  endfunction

  // Take a save of slot s if it is dirty, free, credited and due.
  function logic [2:0] try_capture(int s, logic [31:0] now, bit fin);
    bit age_due, chg_due;
    if (in_flight[s] || busy_saves >= credits() || cur_rev[s] == done_rev[s] ||
        (!fin && now < retry_at[s]))
      return ST_REFUSED;
    age_due = now >= dirty_at[s] && (now - dirty_at[s]) >= age_flush;
    chg_due = chg_sum[s] >= chg_thr && now >= saved_at[s] && (now - saved_at[s]) >= min_gap;
    if (!fin && !flush_req[s] && !age_due && !chg_due)
      return ST_REFUSED;
    in_flight[s]  = 1;
    flight_rev[s] = cur_rev[s];
    flush_req[s]  = 0;
    chg_sum[s]    = 0;
    saved_at[s]   = now;
    busy_saves++;
    return ST_OK;
  endfunction

  function void note_item(logic [2:0] kind, logic [3:0] s, logic [31:0] now,
                          logic [7:0] chg, bit fin, logic [4:0] budget,
                          logic [31:0] g_in, logic [31:0] r_in, bit ok);
    int unsigned n, cnt, cand, pos;
    logic [2:0] st;
    logic [16:0] sum;
    if (kind == KIND_SCAN) begin
      n = 0; cnt = 0;
      for (int i = 0; i < 16; i++) if (opened[i]) cnt++;
      if (cnt > 0 && busy_saves < credits()) begin
        cand = (budget < cnt) ? budget : cnt;
        pos  = cursor;
        for (int ex = 0; ex < cand && busy_saves < credits(); ex++) begin
          do pos = (pos + 1) % 16; while (!opened[pos]);
          cursor = pos;
          if (try_capture(pos, now, 0) == ST_OK) begin
            push(ST_OK, pos[3:0], gen_of[pos], flight_rev[pos], 0);
            n++;
          end
        end
      end
      if (n == 0) push(ST_REFUSED, 0, 0, 0, 1);
      else expected_results[expected_results.size() - 1].last = 1;
      return;
    end
    if (kind > KIND_COMPLETE) begin
      push(ST_REFUSED, s, 0, 0, 1);
      return;
    end
    if (kind == KIND_OPEN) begin
      if (!opened[s]) begin
        if (gen_next == M32) begin
          push(ST_REFUSED, s, 0, 0, 1);
          return;
        end
        opened[s] = 1; gen_of[s] = gen_next; gen_next++;
        cur_rev[s] = 0; done_rev[s] = 0; in_flight[s] = 0; flight_rev[s] = 0;
        dirty_at[s] = 0; chg_sum[s] = 0; saved_at[s] = 0; retry_at[s] = 0;
        flush_req[s] = 0; failed[s] = 0;
      end
      push(ST_OK, s, gen_of[s], cur_rev[s], 1);
      return;
    end
    if (!opened[s]) begin
      push(ST_NOSLOT, s, 0, 0, 1);
      return;
    end
    st = ST_OK;
    case (kind)
      KIND_DIRTY: begin
        if (cur_rev[s] == M32) st = ST_REVEXH;
        else begin
          // restart the age only when the slot was clean or fully in flight
          if (cur_rev[s] == done_rev[s] || (in_flight[s] && cur_rev[s] == flight_rev[s]))
            dirty_at[s] = now;
          cur_rev[s]++;
          sum = chg_sum[s] + chg;
          chg_sum[s] = sum[16] ? 16'hFFFF : sum[15:0];
        end
      end
      KIND_FLUSH: begin
        if (cur_rev[s] != done_rev[s] && (!in_flight[s] || flight_rev[s] != cur_rev[s]))
          flush_req[s] = 1;
      end
      KIND_CAPTURE: begin
        st = try_capture(s, now, fin);
        if (st == ST_OK) begin
          push(ST_OK, s, gen_of[s], flight_rev[s], 1);
          return;
        end
      end
      default: begin
        if (gen_of[s] != g_in || !in_flight[s] || flight_rev[s] != r_in) st = ST_STALE;
        else begin
          if (busy_saves > 0) busy_saves--;
          in_flight[s] = 0;
          failed[s]    = !ok;
          if (ok) begin
            done_rev[s] = r_in;
            retry_at[s] = 0;
          end else begin
            flush_req[s] = 1;
            retry_at[s]  = (M32 - now < min_gap) ? M32 : now + min_gap;
          end
          push(ST_OK, s, gen_of[s], r_in, 1);
          return;
        end
      end
    endcase
    push(st, s, gen_of[s], cur_rev[s], 1);
  endfunction

  function void check_result(logic [2:0] st, logic [3:0] sl, logic [31:0] g,
                             logic [31:0] r, logic lst);
    sched_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: status %0d slot %0d", st, sl);
      errors++;
      return;
    end
    e = expected_results[0];
    expected_results.delete(0);
    if (st !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, st); errors++;
    end
    if (sl !== e.slot) begin
      $error("slot_out: expected %0d, actual %0d", e.slot, sl); errors++;
    end
    if (g !== e.gen) begin
      $error("gen_out: expected %0h, actual %0h", e.gen, g); errors++;
    end
    if (r !== e.rev) begin
      $error("rev_out: expected %0h, actual %0h", e.rev, r); errors++;
    end
    if (lst !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, lst); errors++;
    end
  endfunction
endclass

module tb_write_back_save_scheduler;
  localparam int STALL_LIMIT = 5000;  // cycles without any handshake

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_kind = KIND_OPEN;
  logic [3:0]  in_slot = '0;
  logic [31:0] in_now_ms = '0;
  logic [7:0]  in_change_count = '0;
  logic        in_final_save = 0;
  logic [4:0]  in_scan_budget = '0;
  logic [31:0] in_gen_in = '0;
  logic [31:0] in_rev_in = '0;
  logic        in_success = 0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [31:0] out_gen_out;
  logic [31:0] out_rev_out;
  logic        out_last;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = CFG_AGE;
  logic [31:0] cfg_data = '0;

  save_sched_sb sb = new();
  logic [31:0]  clock_ms = 0;   // running time stamp fed to now_ms
  int           stall_cnt = 0;

  always #5 clk = ~clk;

  write_back_save_scheduler dut (.*);

  // Check every result strobe against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_slot_out, out_gen_out, out_rev_out, out_last);
  end

  // Watchdog: end the run if no item or result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_cmd(logic [2:0] k, logic [3:0] s, logic [31:0] now,
                          logic [7:0] chg, bit fin, logic [4:0] budget,
                          logic [31:0] g, logic [31:0] r, bit ok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1;
    in_kind         <= k;
    in_slot         <= s;
    in_now_ms       <= now;
    in_change_count <= chg;
    in_final_save   <= fin;
    in_scan_budget  <= budget;
    in_gen_in       <= g;
    in_rev_in       <= r;
    in_success      <= ok;
    do @(posedge clk); while (busy);
    sb.note_item(k, s, now, chg, fin, budget, g, r, ok);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.expected_results.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Raise the write enable with one register write; the caller drops it.
  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.cfg_write(idx, d);
  endtask

  task automatic set_regs(logic [31:0] age, logic [31:0] gap, logic [31:0] thr,
                          logic [31:0] lim);
    write_reg(CFG_AGE, age);
    write_reg(CFG_INTERVAL, gap);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_LIMIT, lim);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Random item: mostly well-formed traffic, completions usually name the
  // save that is really in flight; a few use noise time stamps and tags.
  task automatic rand_item();
    logic [2:0]  k;
    logic [3:0]  s;
    logic [31:0] g, r, now;
    int          w;
    w = $urandom_range(0, 99);
    s = 4'($urandom_range(0, 15));
    if (w < 8) k = KIND_OPEN;
    else if (w < 38) k = KIND_DIRTY;
    else if (w < 46) k = KIND_FLUSH;
    else if (w < 64) k = KIND_CAPTURE;
    else if (w < 76) k = KIND_SCAN;
    else k = KIND_COMPLETE;
    // advance time, now and then jump anywhere
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 80);
    now = clock_ms;
    g = $urandom();
    r = $urandom();
    if (k == KIND_COMPLETE && sb.in_flight[s] && $urandom_range(0, 9) < 8) begin
      g = sb.gen_of[s];
      r = sb.flight_rev[s];
    end else if (k == KIND_COMPLETE && $urandom_range(0, 1) == 1) begin
      g = sb.gen_of[s];
      r = sb.cur_rev[s];
    end
    send_cmd(k, s, now, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
             5'($urandom_range(0, 16)), g, r, $urandom_range(0, 9) < 7);
  endtask

  task automatic rand_phase(int n);
    repeat (n) rand_item();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, missing slots, reopen, unknown kind, empty scan,
    // flush-driven capture, stale and failed completions, final save.
    send_cmd(KIND_SCAN, 0, 0, 0, 0, 16, 0, 0, 0);
    send_cmd(KIND_DIRTY, 5, 0, 255, 0, 0, 0, 0, 0);
    send_cmd(KIND_FLUSH, 5, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAPTURE, 5, 0, 0, 1, 0, 0, 0, 0);
    send_cmd(KIND_COMPLETE, 5, 0, 0, 0, 0, 1, 0, 1);
    send_cmd(3'd7, 9, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_OPEN, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_OPEN, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_OPEN, 15, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_FLUSH, 0, 10, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAPTURE, 0, 10, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_DIRTY, 0, 20, 255, 0, 0, 0, 0, 0);
    send_cmd(KIND_FLUSH, 0, 30, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAPTURE, 0, 40, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_FLUSH, 0, 45, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_COMPLETE, 0, 50, 0, 0, 0, 32'd99, 32'd1, 1);
    send_cmd(KIND_COMPLETE, 0, 32'hFFFF_F000, 0, 0, 0, 32'd1, 32'd1, 0);
    send_cmd(KIND_CAPTURE, 0, 32'hFFFF_F100, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAPTURE, 0, 32'hFFFF_F100, 0, 1, 0, 0, 0, 0);
    send_cmd(KIND_COMPLETE, 0, 32'hFFFF_F200, 0, 0, 0, 32'd1, 32'd1, 1);
    send_cmd(KIND_DIRTY, 15, 60, 1, 0, 0, 0, 0, 0);
    send_cmd(KIND_SCAN, 0, 32'd40000, 0, 0, 16, 0, 0, 0);
    send_cmd(KIND_SCAN, 0, 32'd40000, 0, 0, 0, 0, 0, 0);
    drain();
    clock_ms = 32'd100;

    // Everything due at once, credit register above the slot count.
    set_regs(32'd0, 32'd0, 32'd0, 32'd31);
    rand_phase(30);

    // Nothing due, no credit at all.
    set_regs(M32, M32, 32'hFFFF, 32'd0);
    rand_phase(20);

    // Saturate the change total on one slot, then save on threshold.
    set_regs(M32, 32'd0, 32'hFFFF, 32'd16);
    send_cmd(KIND_OPEN, 3, clock_ms, 0, 0, 0, 0, 0, 0);
    repeat (258) send_cmd(KIND_DIRTY, 3, clock_ms, 8'hFF, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAPTURE, 3, clock_ms + 1, 0, 0, 0, 0, 0, 0);
    drain();

    // Tight credit, short timers.
    set_regs(32'd150, 32'd40, 32'd200, 32'd1);
    rand_phase(35);

    // Random moderate settings.
    set_regs($urandom_range(0, 300), $urandom_range(0, 100), $urandom_range(0, 400),
             $urandom_range(1, 16));
    rand_phase(35);

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[filelist.f]
rtl/wbs_pkg.sv
rtl/wbs_front.sv
rtl/wbs_back.sv
rtl/write_back_save_scheduler.sv
dv/tb_write_back_save_scheduler.sv
